@@ sv/cpg_pkg.sv @@
`timescale 1ns / 1ps

package cpg_pkg;

    localparam int PHASE_BITS  = 24;
    localparam int MIN_TICK_MS = 5;

    // Widths of the phase-step division.
    localparam int NUM_W      = 48;
    localparam int DEN_W      = 33;
    localparam int DIV_STEPS  = NUM_W + PHASE_BITS + 8;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int FRAC_BITS  = PHASE_BITS - 2;
    localparam int ZPROD_W    = FRAC_BITS + 19;

    localparam logic [20:0] TWO_PI_1000_Q8 = 21'd1608495;
    localparam logic [18:0] TWO_PI_Q16     = 19'd411775;

    // CORDIC datapath.
    localparam int CORDIC_STAGES = 16;
    localparam int XY_W          = 32;
    localparam int Z_W           = 19;
    localparam int ANG_W         = 17;
    localparam logic signed [XY_W-1:0] CORDIC_START = 32'sd652032874;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] KIND_LEAD_IN = 2'd0;
    localparam logic [1:0] KIND_POINT   = 2'd1;
    localparam logic [1:0] KIND_HOME    = 2'd2;

    localparam logic [2:0] REG_SPEED    = 3'd0;
    localparam logic [2:0] REG_CENTER_X = 3'd1;
    localparam logic [2:0] REG_CENTER_Z = 3'd2;
    localparam logic [2:0] REG_RADIUS   = 3'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULT,
        S_DIV,
        S_ANGLE,
        S_CORDIC,
        S_SCALE,
        S_SUM,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_vec_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [ANG_W-1:0] atan_q16(input logic [3:0] i);
        logic [ANG_W-1:0] a;
        unique case (i)
            4'd0:    a = 17'd51472;
            4'd1:    a = 17'd30386;
            4'd2:    a = 17'd16055;
            4'd3:    a = 17'd8150;
            4'd4:    a = 17'd4091;
            4'd5:    a = 17'd2047;
            4'd6:    a = 17'd1024;
            4'd7:    a = 17'd512;
            4'd8:    a = 17'd256;
            4'd9:    a = 17'd128;
            4'd10:   a = 17'd64;
            4'd11:   a = 17'd32;
            4'd12:   a = 17'd16;
            4'd13:   a = 17'd8;
            4'd14:   a = 17'd4;
            default: a = 17'd2;
        endcase
        return a;
    endfunction

endpackage

@@ sv/circle_path_generator.sv @@
`timescale 1ns / 1ps

// Circle path generator: start, stop and tick commands come in one per
// transaction. Start and stop go to the emit state, which loads the output
// register once it is free, and then return to idle for the next command. A
// tick that advances the circle runs the 80-step restoring divider that turns
// speed*dt into a phase step (one quotient bit a cycle), then the 16-cell
// CORDIC chain, scales by the radius and presents its point. Ticks that
// produce no point leave the generator in idle and give no output. A finished
// result waits in the output register while the next command is taken.
// Configuration writes are taken at any time but should only be issued while
// no command is in flight; index 4 and above are ignored.
module circle_path_generator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [31:0]        now_ms,
    input  logic               planner_idle,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         command_kind,
    output logic signed [15:0] pos_x,
    output logic signed [15:0] pos_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    cpg_pkg::state_t state_reg, state_next;

    logic [15:0]        speed_reg;
    logic signed [14:0] center_x_reg;
    logic signed [14:0] center_z_reg;
    logic [11:0]        radius_reg;

    logic                             running_reg, running_next;
    logic                             lead_reg, lead_next;
    logic [cpg_pkg::PHASE_BITS-1:0]   phase_reg, phase_next;
    logic [31:0]                      last_reg, last_next;
    logic [31:0]                      dt_reg, dt_next;

    logic [cpg_pkg::NUM_W-1:0]        num_reg, num_next;
    logic [cpg_pkg::DEN_W-1:0]        den_reg, den_next;
    logic [cpg_pkg::ZPROD_W-1:0]      zprod_reg, zprod_next;
    logic signed [44:0]               prod_x_reg, prod_x_next;
    logic signed [44:0]               prod_z_reg, prod_z_next;
    logic signed [cpg_pkg::XY_W-1:0]  rot_c, rot_s;
    logic signed [44:0]               off_x, off_z;

    logic [1:0]         res_kind_reg, res_kind_next;
    logic signed [15:0] res_x_reg, res_x_next;
    logic signed [15:0] res_z_reg, res_z_next;

    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_kind_reg, out_kind_next;
    logic signed [15:0] out_x_reg, out_x_next;
    logic signed [15:0] out_z_reg, out_z_next;

    logic                  div_start;
    cpg_pkg::div_stat_t    div_stat;
    logic [cpg_pkg::PHASE_BITS-1:0] div_quot;

    // Launch pulse: first cycle in the CORDIC wait state.
    logic                  cor_launch_reg;
    cpg_pkg::cordic_vec_t  cor_in;
    logic                  cor_valid;
    cpg_pkg::cordic_vec_t  cor_out;

    logic        in_fire;
    logic [31:0] tick_dt;

    assign in_fire   = in_valid && in_ready;
    assign in_ready  = (state_reg == cpg_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign tick_dt   = now_ms - last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg    <= 16'd1200;
            center_x_reg <= 15'sd1024;
            center_z_reg <= 15'sd1728;
            radius_reg   <= 12'd256;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cpg_pkg::REG_SPEED:    speed_reg    <= cfg_data;
                cpg_pkg::REG_CENTER_X: center_x_reg <= cfg_data[14:0];
                cpg_pkg::REG_CENTER_Z: center_z_reg <= cfg_data[14:0];
                cpg_pkg::REG_RADIUS:   radius_reg   <= cfg_data[11:0];
                default:               ;
            endcase
        end
    end

    // The divider loads its dividend on the start cycle, so it takes the
    // product as it is being formed.
    cpg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_next),
        .den   (den_reg),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    assign cor_in.x = cpg_pkg::CORDIC_START;
    assign cor_in.y = '0;
    assign cor_in.z = $signed({2'b00,
                               zprod_reg[cpg_pkg::ZPROD_W-1:cpg_pkg::PHASE_BITS]});

    cpg_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cor_launch_reg),
        .in_vec    (cor_in),
        .out_valid (cor_valid),
        .out_vec   (cor_out)
    );

    // Quadrant rotation of the first-quadrant CORDIC result.
    always_comb
    begin
        unique case (phase_reg[cpg_pkg::PHASE_BITS-1 -: 2])
            2'd0:
            begin
                rot_c = cor_out.x;
                rot_s = cor_out.y;
            end
            2'd1:
            begin
                rot_c = -cor_out.y;
                rot_s = cor_out.x;
            end
            2'd2:
            begin
                rot_c = -cor_out.x;
                rot_s = -cor_out.y;
            end
            default:
            begin
                rot_c = cor_out.y;
                rot_s = -cor_out.x;
            end
        endcase
        off_x = (prod_x_reg + 45'sd536870912) >>> 30;
        off_z = (prod_z_reg + 45'sd536870912) >>> 30;
    end

    always_comb
    begin
        state_next     = state_reg;
        running_next   = running_reg;
        lead_next      = lead_reg;
        phase_next     = phase_reg;
        last_next      = last_reg;
        dt_next        = dt_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        zprod_next     = zprod_reg;
        prod_x_next    = prod_x_reg;
        prod_z_next    = prod_z_reg;
        res_kind_next  = res_kind_reg;
        res_x_next     = res_x_reg;
        res_z_next     = res_z_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_kind_next  = out_kind_reg;
        out_x_next     = out_x_reg;
        out_z_next     = out_z_reg;
        div_start      = 1'b0;

        unique case (state_reg)
            cpg_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    priority if (opcode == cpg_pkg::OP_START)
                    begin
                        running_next  = 1'b1;
                        lead_next     = 1'b1;
                        phase_next    = '0;
                        last_next     = now_ms;
                        res_kind_next = cpg_pkg::KIND_LEAD_IN;
                        res_x_next    = 16'(center_x_reg) + $signed({4'b0, radius_reg});
                        res_z_next    = 16'(center_z_reg);
                        state_next    = cpg_pkg::S_EMIT;
                    end
                    else if (opcode == cpg_pkg::OP_STOP)
                    begin
                        running_next  = 1'b0;
                        res_kind_next = cpg_pkg::KIND_HOME;
                        res_x_next    = '0;
                        res_z_next    = '0;
                        state_next    = cpg_pkg::S_EMIT;
                    end
                    else if (opcode == cpg_pkg::OP_TICK && running_reg)
                    begin
                        if (lead_reg)
                        begin
                            if (planner_idle)
                            begin
                                lead_next = 1'b0;
                                last_next = now_ms;
                            end
                        end
                        else if (tick_dt >= 32'(cpg_pkg::MIN_TICK_MS))
                        begin
                            last_next  = now_ms;
                            dt_next    = tick_dt;
                            state_next = cpg_pkg::S_MULT;
                        end
                    end
                end
            end
            cpg_pkg::S_MULT:
            begin
                num_next   = 48'(speed_reg) * 48'(dt_reg);
                den_next   = 33'(radius_reg) * 33'(cpg_pkg::TWO_PI_1000_Q8);
                div_start  = 1'b1;
                state_next = cpg_pkg::S_DIV;
            end
            cpg_pkg::S_DIV:
            begin
                if (div_stat.done)
                begin
                    // A zero radius leaves the phase where it is.
                    if (den_reg != '0)
                    begin
                        phase_next = phase_reg + div_quot;
                    end
                    state_next = cpg_pkg::S_ANGLE;
                end
            end
            cpg_pkg::S_ANGLE:
            begin
                zprod_next = cpg_pkg::ZPROD_W'(phase_reg[cpg_pkg::FRAC_BITS-1:0])
                           * cpg_pkg::ZPROD_W'(cpg_pkg::TWO_PI_Q16);
                state_next = cpg_pkg::S_CORDIC;
            end
            cpg_pkg::S_CORDIC:
            begin
                if (cor_valid)
                begin
                    prod_x_next = 45'($signed({1'b0, radius_reg})) * 45'(rot_c);
                    prod_z_next = 45'($signed({1'b0, radius_reg})) * 45'(rot_s);
                    state_next  = cpg_pkg::S_SCALE;
                end
            end
            cpg_pkg::S_SCALE:
            begin
                res_kind_next = cpg_pkg::KIND_POINT;
                res_x_next    = 16'(center_x_reg) + off_x[15:0];
                res_z_next    = 16'(center_z_reg) + off_z[15:0];
                state_next    = cpg_pkg::S_SUM;
            end
            cpg_pkg::S_SUM:
            begin
                state_next = cpg_pkg::S_EMIT;
            end
            cpg_pkg::S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = res_kind_reg;
                    out_x_next     = res_x_reg;
                    out_z_next     = res_z_reg;
                    state_next     = cpg_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cpg_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cpg_pkg::S_IDLE;
            running_reg    <= 1'b0;
            lead_reg       <= 1'b0;
            phase_reg      <= '0;
            last_reg       <= '0;
            out_valid_reg  <= 1'b0;
            cor_launch_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            running_reg    <= running_next;
            lead_reg       <= lead_next;
            phase_reg      <= phase_next;
            last_reg       <= last_next;
            out_valid_reg  <= out_valid_next;
            cor_launch_reg <= (state_reg == cpg_pkg::S_ANGLE);
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg       <= dt_next;
        num_reg      <= num_next;
        den_reg      <= den_next;
        zprod_reg    <= zprod_next;
        prod_x_reg   <= prod_x_next;
        prod_z_reg   <= prod_z_next;
        res_kind_reg <= res_kind_next;
        res_x_reg    <= res_x_next;
        res_z_reg    <= res_z_next;
        out_kind_reg <= out_kind_next;
        out_x_reg    <= out_x_next;
        out_z_reg    <= out_z_next;
    end

    assign out_valid    = out_valid_reg;
    assign command_kind = out_kind_reg;
    assign pos_x        = out_x_reg;
    assign pos_z        = out_z_reg;

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == cpg_pkg::S_DIV)
        else $error("divider finished outside the divide state");

    a_cordic_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cor_valid |-> state_reg == cpg_pkg::S_CORDIC)
        else $error("CORDIC result outside the CORDIC wait state");

    a_stop_clears_running: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && opcode == cpg_pkg::OP_STOP) |=> !running_reg)
        else $error("stop command left the generator running");

endmodule

@@ sv/cpg_div.sv @@
`timescale 1ns / 1ps

module cpg_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [cpg_pkg::NUM_W-1:0]        num,
    input  logic [cpg_pkg::DEN_W-1:0]        den,
    output cpg_pkg::div_stat_t               stat,
    output logic [cpg_pkg::PHASE_BITS-1:0]   quot
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [cpg_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [cpg_pkg::DEN_W-1:0]         rem_reg, rem_next;
    logic [cpg_pkg::NUM_W-1:0]         dvd_reg, dvd_next;
    logic [cpg_pkg::PHASE_BITS-1:0]    quot_reg, quot_next;
    logic [cpg_pkg::DEN_W:0]           trial;
    logic [cpg_pkg::DEN_W:0]           diff;
    logic                              ge;

    // The dividend is shifted in MSB first, followed by zeros; only the last
    // quotient bits are kept, which is the fraction of a turn.
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[cpg_pkg::NUM_W-1]};
        ge        = trial >= {1'b0, den};
        diff      = trial - {1'b0, den};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = num;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[cpg_pkg::DEN_W-1:0] : trial[cpg_pkg::DEN_W-1:0];
            dvd_next  = {dvd_reg[cpg_pkg::NUM_W-2:0], 1'b0};
            quot_next = {quot_reg[cpg_pkg::PHASE_BITS-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == cpg_pkg::DIV_CNT_W'(cpg_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

@@ sv/cpg_cordic_cell.sv @@
`timescale 1ns / 1ps

module cpg_cordic_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  cpg_pkg::cordic_vec_t         in_vec,
    input  logic [3:0]                   shift,
    input  logic [cpg_pkg::ANG_W-1:0]    angle,
    output logic                         out_valid,
    output cpg_pkg::cordic_vec_t         out_vec
);

    logic                  valid_reg;
    cpg_pkg::cordic_vec_t  vec_reg, vec_next;
    logic signed [cpg_pkg::XY_W-1:0] xs;
    logic signed [cpg_pkg::XY_W-1:0] ys;
    logic signed [cpg_pkg::Z_W-1:0]  ang;

    always_comb
    begin
        xs  = in_vec.x >>> shift;
        ys  = in_vec.y >>> shift;
        ang = $signed({{(cpg_pkg::Z_W - cpg_pkg::ANG_W){1'b0}}, angle});
        if (!in_vec.z[cpg_pkg::Z_W-1])
        begin
            vec_next.x = in_vec.x - ys;
            vec_next.y = in_vec.y + xs;
            vec_next.z = in_vec.z - ang;
        end
        else
        begin
            vec_next.x = in_vec.x + ys;
            vec_next.y = in_vec.y - xs;
            vec_next.z = in_vec.z + ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg <= vec_next;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

@@ sv/cpg_cordic.sv @@
`timescale 1ns / 1ps

module cpg_cordic (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  cpg_pkg::cordic_vec_t  in_vec,
    output logic                  out_valid,
    output cpg_pkg::cordic_vec_t  out_vec
);

    logic                  vld [0:cpg_pkg::CORDIC_STAGES];
    cpg_pkg::cordic_vec_t  vec [0:cpg_pkg::CORDIC_STAGES];

    assign vld[0] = in_valid;
    assign vec[0] = in_vec;

    for (genvar i = 0; i < cpg_pkg::CORDIC_STAGES; i++)
    begin : g_cell
        cpg_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld[i]),
            .in_vec    (vec[i]),
            .shift     (4'(i)),
            .angle     (cpg_pkg::atan_q16(4'(i))),
            .out_valid (vld[i+1]),
            .out_vec   (vec[i+1])
        );
    end

    assign out_valid = vld[cpg_pkg::CORDIC_STAGES];
    assign out_vec   = vec[cpg_pkg::CORDIC_STAGES];

endmodule
